### rtl/iepf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iepf_pkg
// Shared constants and types for the icmp echo parity packet filter.
// ----------------------------------------------------------------------------
package iepf_pkg;

  localparam logic [15:0] ETYPE_CTAG = 16'h8100;
  localparam logic [15:0] ETYPE_STAG = 16'h88A8;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;

  localparam logic [7:0] PROTO_ICMPV4    = 8'd1;
  localparam logic [7:0] PROTO_ICMPV6    = 8'd58;
  localparam logic [7:0] ICMPV4_ECHO_REQ = 8'd8;
  localparam logic [7:0] ICMPV6_ECHO_REQ = 8'd128;

  localparam logic [1:0] MAX_TAGS = 2'd2;

  localparam logic [6:0] ETH_TYPE_HI_OFS = 7'd12;
  localparam logic [6:0] ETH_TYPE_LO_OFS = 7'd13;
  localparam logic [6:0] ETH_HDR_LEN     = 7'd14;
  localparam logic [6:0] TAG_LEN         = 7'd4;
  localparam logic [6:0] IPV6_HDR_LEN    = 7'd40;
  localparam logic [5:0] IPV4_MIN_LEN    = 6'd20;
  localparam logic [6:0] OFS_MAX         = 7'd127;

  localparam logic [1:0] ECHO_NONE = 2'd0;
  localparam logic [1:0] ECHO_IPV4 = 2'd1;
  localparam logic [1:0] ECHO_IPV6 = 2'd2;

  typedef struct packed {
    logic        drop;
    logic [1:0]  echo_kind;
    logic [15:0] echo_sequence;
  } verdict_t;

endpackage

### rtl/icmp_echo_parity_packet_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icmp_echo_parity_packet_filter
// Drops icmp/icmpv6 echo requests with an even sequence number.
// ----------------------------------------------------------------------------
// Frames enter one byte per beat with last_byte on the final byte. The block
// takes one byte every cycle while data_ready is high; each byte goes through
// one layer of header compares into the parser registers. The verdict for a
// frame appears in the result register on the cycle after its last byte is
// taken, and a new byte is accepted whenever that register is empty or being
// read in the same cycle. Headers walked: ethernet, up to two 802.1Q/802.1ad
// tags, ipv4 or ipv6, the 8-byte icmp header. Other or truncated frames pass.
module icmp_echo_parity_packet_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        drop,
  output logic [1:0]  echo_kind,
  output logic [15:0] echo_sequence
);

  iepf_pkg::verdict_t verdict;
  iepf_pkg::verdict_t result;
  logic               beat;

  assign data_ready = !result_valid || result_ready;
  assign beat       = data_valid && data_ready;

  iepf_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .beat      (beat),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .verdict   (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (beat && last_byte) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat && last_byte) begin
      result <= verdict;
    end
  end

  assign drop          = result.drop;
  assign echo_kind     = result.echo_kind;
  assign echo_sequence = result.echo_sequence;

`ifndef ASSERT_OFF
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (data_valid && data_ready && last_byte) |=> result_valid)
    else $error("last beat did not produce a result");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> data_ready)
    else $error("input stalled with empty result register");

  a_drop_needs_echo: assert property (@(posedge clk) disable iff (rst)
    (result_valid && drop) |-> (echo_kind != iepf_pkg::ECHO_NONE && !echo_sequence[0]))
    else $error("drop without even echo request");

  a_no_echo_no_seq: assert property (@(posedge clk) disable iff (rst)
    (result_valid && echo_kind == iepf_pkg::ECHO_NONE) |-> (echo_sequence == 16'h0000))
    else $error("sequence reported without echo");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (echo_kind != 2'd3))
    else $error("bad echo kind");
`endif

endmodule

### rtl/iepf_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iepf_parser
// Byte-wise header walker: ethernet, vlan tags, ipv4/ipv6, icmp header.
// ----------------------------------------------------------------------------
module iepf_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                beat,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output iepf_pkg::verdict_t  verdict
);

  typedef enum logic [3:0] {
    PH_ETH, PH_TAG, PH_IP4, PH_IP6, PH_ICMP4, PH_ICMP6, PH_DONE
  } phase_t;

  phase_t      parse_phase, parse_phase_next;
  logic [6:0]  byte_offset, byte_offset_next;
  logic [15:0] ether_type, ether_type_next;
  logic [1:0]  tag_count, tag_count_next;
  logic [6:0]  layer_start, layer_start_next;
  logic [5:0]  ipv4_header_len, ipv4_header_len_next;
  logic [7:0]  next_protocol, next_protocol_next;
  logic [7:0]  icmp_type_seen, icmp_type_seen_next;
  logic [15:0] sequence_seen, sequence_seen_next;
  logic [1:0]  echo_found, echo_found_next;
  logic [6:0]  rel;

  function automatic phase_t link_next(input logic [15:0] et, input logic [1:0] tags);
    phase_t ph;
    if ((et == iepf_pkg::ETYPE_CTAG || et == iepf_pkg::ETYPE_STAG)
        && tags < iepf_pkg::MAX_TAGS) begin
      ph = PH_TAG;
    end else if (et == iepf_pkg::ETYPE_IPV6) begin
      ph = PH_IP6;
    end else if (et == iepf_pkg::ETYPE_IPV4) begin
      ph = PH_IP4;
    end else begin
      ph = PH_DONE;
    end
    return ph;
  endfunction

  assign rel = byte_offset - layer_start;

  always_comb begin
    parse_phase_next     = parse_phase;
    ether_type_next      = ether_type;
    tag_count_next       = tag_count;
    layer_start_next     = layer_start;
    ipv4_header_len_next = ipv4_header_len;
    next_protocol_next   = next_protocol;
    icmp_type_seen_next  = icmp_type_seen;
    sequence_seen_next   = sequence_seen;
    echo_found_next      = echo_found;
    byte_offset_next     = (byte_offset < iepf_pkg::OFS_MAX) ? byte_offset + 7'd1 : byte_offset;

    unique case (parse_phase)
      PH_ETH: begin
        if (byte_offset == iepf_pkg::ETH_TYPE_HI_OFS) begin
          ether_type_next = {data_byte, 8'h00};
        end else if (byte_offset == iepf_pkg::ETH_TYPE_LO_OFS) begin
          ether_type_next  = {ether_type[15:8], data_byte};
          layer_start_next = iepf_pkg::ETH_HDR_LEN;
          parse_phase_next = link_next({ether_type[15:8], data_byte}, tag_count);
        end
      end
      PH_TAG: begin
        if (rel == 7'd2) begin
          next_protocol_next = data_byte;
        end else if (rel == 7'd3) begin
          ether_type_next    = {next_protocol, data_byte};
          next_protocol_next = 8'h00;
          tag_count_next     = tag_count + 2'd1;
          layer_start_next   = layer_start + iepf_pkg::TAG_LEN;
          parse_phase_next   = link_next({next_protocol, data_byte}, tag_count + 2'd1);
        end
      end
      PH_IP4: begin
        if (rel == 7'd0) begin
          ipv4_header_len_next = {data_byte[3:0], 2'b00};
          if ({data_byte[3:0], 2'b00} < iepf_pkg::IPV4_MIN_LEN) begin
            parse_phase_next = PH_DONE;
          end
        end else if (rel == 7'd9) begin
          next_protocol_next = data_byte;
        end
        if (parse_phase_next == PH_IP4 && rel >= 7'd19
            && ({1'b0, rel} + 8'd1) == {2'b00, ipv4_header_len_next}) begin
          if (next_protocol_next == iepf_pkg::PROTO_ICMPV4) begin
            layer_start_next = layer_start + {1'b0, ipv4_header_len_next};
            parse_phase_next = PH_ICMP4;
          end else begin
            parse_phase_next = PH_DONE;
          end
        end
      end
      PH_IP6: begin
        if (rel == 7'd6) begin
          next_protocol_next = data_byte;
        end else if (rel == 7'd39) begin
          if (next_protocol == iepf_pkg::PROTO_ICMPV6) begin
            layer_start_next = layer_start + iepf_pkg::IPV6_HDR_LEN;
            parse_phase_next = PH_ICMP6;
          end else begin
            parse_phase_next = PH_DONE;
          end
        end
      end
      PH_ICMP4, PH_ICMP6: begin
        if (rel == 7'd0) begin
          icmp_type_seen_next = data_byte;
        end else if (rel == 7'd6) begin
          sequence_seen_next = {data_byte, 8'h00};
        end else if (rel == 7'd7) begin
          sequence_seen_next = {sequence_seen[15:8], data_byte};
          if (parse_phase == PH_ICMP4 && icmp_type_seen == iepf_pkg::ICMPV4_ECHO_REQ) begin
            echo_found_next = iepf_pkg::ECHO_IPV4;
          end else if (parse_phase == PH_ICMP6
                       && icmp_type_seen == iepf_pkg::ICMPV6_ECHO_REQ) begin
            echo_found_next = iepf_pkg::ECHO_IPV6;
          end
          parse_phase_next = PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  // verdict on the byte just taken, used only when it is the last one
  always_comb begin
    verdict.drop          = (echo_found_next != iepf_pkg::ECHO_NONE) && !sequence_seen_next[0];
    verdict.echo_kind     = echo_found_next;
    verdict.echo_sequence = (echo_found_next != iepf_pkg::ECHO_NONE) ? sequence_seen_next
                                                                       : 16'h0000;
  end

  always_ff @(posedge clk) begin
    if (rst || (beat && last_byte)) begin
      parse_phase     <= PH_ETH;
      byte_offset     <= '0;
      ether_type      <= '0;
      tag_count       <= '0;
      layer_start     <= '0;
      ipv4_header_len <= '0;
      next_protocol   <= '0;
      icmp_type_seen  <= '0;
      sequence_seen   <= '0;
      echo_found      <= iepf_pkg::ECHO_NONE;
    end else if (beat) begin
      parse_phase     <= parse_phase_next;
      byte_offset     <= byte_offset_next;
      ether_type      <= ether_type_next;
      tag_count       <= tag_count_next;
      layer_start     <= layer_start_next;
      ipv4_header_len <= ipv4_header_len_next;
      next_protocol   <= next_protocol_next;
      icmp_type_seen  <= icmp_type_seen_next;
      sequence_seen   <= sequence_seen_next;
      echo_found      <= echo_found_next;
    end
  end

endmodule
